### hw/rtl/indent_dedent_token_scanner_unit_assert.svh
// Assertion macros shared by the indent/dedent scanner RTL.
`ifndef INDENT_DEDENT_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define INDENT_DEDENT_TOKEN_SCANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IDTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idts: same-cycle check failed");
`define IDTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idts: next-cycle check failed");
`else
`define IDTS_ASSERT_IMP(label, ante, cons)
`define IDTS_ASSERT_NXT(label, ante, cons)
`endif
`endif

### hw/rtl/idts_pkg.sv
// Shared types and constants of the indent/dedent token scanner.
`default_nettype none
package idts_pkg;

    localparam int CHAR_WIDTH = 21;

    localparam logic [CHAR_WIDTH-1:0] CHAR_NL    = 21'h00000A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 21'h000020;
    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 21'h000009;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 21'h00000D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_FF    = 21'h00000C;

    localparam int TAB_STEP = 8;

    typedef enum logic [1:0] {
        TOK_NONE    = 2'd0,
        TOK_NEWLINE = 2'd1,
        TOK_INDENT  = 2'd2,
        TOK_DEDENT  = 2'd3
    } tok_kind_t;

    // Flags carried with each scan-end entry from front to back
    typedef struct packed {
        logic line_end;
        logic ok_newline;
        logic ok_indent;
        logic ok_dedent;
    } idts_flags_t;

    localparam int FLAGS_WIDTH = $bits(idts_flags_t);

endpackage
`default_nettype wire

### hw/rtl/indent_dedent_token_scanner_unit.sv
// Top level of the indent/dedent token scanner.
`default_nettype none
// Offside-rule scanner: one lookahead character per slave transaction, with the
// parser's allowed-token flags. Blank characters only update the column and
// line-end mark and give no result; the character that ends a scan (non-blank
// or end of file) gives exactly one master transaction with the token kind and
// the overflow flag. A scan-end entry passes through a two-entry queue to the
// stack unit, which decides the token and loads the result register that drives
// m_tvalid. The input takes one character per cycle except in a cycle in which
// the queue holds two entries, which happens while m_tready is held low or the
// stack unit waits. The stack sits in a RAM with a registered read that prefetches
// the entry below the top: a DEDENT taken in the cycle right after another push or
// pop waits for that read unless only two entries are left, so the DEDENTs of a
// run are not taken back to back.
module indent_dedent_token_scanner_unit
    import idts_pkg::*;
#(
    parameter int STACK_DEPTH  = 32,
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // scan_start[0], char_code[21:1], at_eof[22], valid_newline[23],
    // valid_indent[24], valid_dedent[25], zero[31:26]
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // stack_overflow[0], zero[7:1]
    output logic      [7:0]  m_tdata,
    // token_kind[1:0]
    output logic      [1:0]  m_tuser
);

    localparam int QW = COLUMN_WIDTH + FLAGS_WIDTH;

    logic                    q_push, q_full, q_pop, q_valid;
    logic [COLUMN_WIDTH-1:0] f_col;
    idts_flags_t             f_flags;
    logic [QW-1:0]           q_rd_data;
    idts_flags_t             b_flags;
    tok_kind_t               out_kind;
    logic                    out_ovf;

    idts_front #(
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .scan_start    (s_tdata[0]),
        .char_code     (s_tdata[21:1]),
        .at_eof        (s_tdata[22]),
        .valid_newline (s_tdata[23]),
        .valid_indent  (s_tdata[24]),
        .valid_dedent  (s_tdata[25]),
        .q_push        (q_push),
        .q_col         (f_col),
        .q_flags       (f_flags),
        .q_full        (q_full)
    );

    idts_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  ({f_flags, f_col}),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    assign b_flags = idts_flags_t'(q_rd_data[QW-1:COLUMN_WIDTH]);

    idts_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_col     (q_rd_data[COLUMN_WIDTH-1:0]),
        .q_flags   (b_flags),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_ovf   (out_ovf)
    );

    assign m_tdata = {7'b0, out_ovf};
    assign m_tuser = out_kind;

endmodule
`default_nettype wire

### hw/rtl/idts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module idts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/idts_front.sv
// Front end: column and line-end tracking, hands scan-end entries to the queue.
`default_nettype none
module idts_front
    import idts_pkg::*;
#(
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    scan_start,
    input  wire logic [CHAR_WIDTH-1:0]   char_code,
    input  wire logic                    at_eof,
    input  wire logic                    valid_newline,
    input  wire logic                    valid_indent,
    input  wire logic                    valid_dedent,
    output logic                         q_push,
    output logic [COLUMN_WIDTH-1:0]      q_col,
    output idts_flags_t                  q_flags,
    input  wire logic                    q_full
);

    logic [COLUMN_WIDTH-1:0] col_reg, col_next;
    logic                    le_reg, le_next;

    logic [COLUMN_WIDTH-1:0] col_base;
    logic                    le_base;
    logic [COLUMN_WIDTH:0]   col_sum;
    logic [COLUMN_WIDTH-1:0] col_sat;
    logic                    is_nl, is_space, is_tab, is_zero;
    logic                    scan_end;
    logic                    accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_base = scan_start ? '0 : col_reg;
        le_base  = scan_start ? 1'b0 : le_reg;

        is_nl    = !at_eof && (char_code == CHAR_NL);
        is_space = !at_eof && (char_code == CHAR_SPACE);
        is_tab   = !at_eof && (char_code == CHAR_TAB);
        is_zero  = !at_eof && ((char_code == CHAR_CR) || (char_code == CHAR_FF));
        scan_end = !(is_nl || is_space || is_tab || is_zero);

        col_sum = {1'b0, col_base}
                + (is_tab ? (COLUMN_WIDTH+1)'(TAB_STEP) : (COLUMN_WIDTH+1)'(1));
        // Saturate at all ones
        col_sat = col_sum[COLUMN_WIDTH] ? '1 : col_sum[COLUMN_WIDTH-1:0];

        col_next = col_reg;
        le_next  = le_reg;
        if (accept)
        begin
            priority if (at_eof || is_nl)
            begin
                col_next = '0;
                le_next  = 1'b1;
            end
            else if (is_space || is_tab)
            begin
                col_next = col_sat;
                le_next  = le_base;
            end
            else if (is_zero)
            begin
                col_next = '0;
                le_next  = le_base;
            end
            else
            begin
                col_next = col_base;
                le_next  = le_base;
            end
        end

        q_push             = accept && scan_end;
        q_col              = at_eof ? '0 : col_base;
        q_flags.line_end   = at_eof ? 1'b1 : le_base;
        q_flags.ok_newline = valid_newline;
        q_flags.ok_indent  = valid_indent;
        q_flags.ok_dedent  = valid_dedent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            le_reg  <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            le_reg  <= le_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/idts_queue.sv
// Two-entry queue between the front end and the stack back end.
`default_nettype none
module idts_queue #(
    parameter int WIDTH = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  rd_valid,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    always_comb
    begin
        full        = (fill_reg == 2'd2);
        rd_valid    = (fill_reg != 2'd0);
        rd_data     = slot_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && rd_valid;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/idts_back.sv
// Back end: indent stack decision, stack RAM and result register.
`default_nettype none
`include "indent_dedent_token_scanner_unit_assert.svh"
module idts_back
    import idts_pkg::*;
#(
    parameter int STACK_DEPTH  = 32,
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire logic [COLUMN_WIDTH-1:0] q_col,
    input  wire idts_flags_t             q_flags,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output tok_kind_t                    out_kind,
    output logic                         out_ovf
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]           count_reg, count_next;
    logic [COLUMN_WIDTH-1:0] top_reg, top_next;
    logic                    below_ok_reg, below_ok_next;
    logic                    m_valid_reg, m_valid_next;
    tok_kind_t               m_kind_reg, m_kind_next;
    logic                    m_ovf_reg, m_ovf_next;

    logic [COLUMN_WIDTH-1:0] ram_rdata;
    logic [COLUMN_WIDTH-1:0] below_val;
    logic [AW-1:0]           ram_raddr;
    logic                    has_entry, is_full, two_left;
    logic                    try_indent, do_push, do_ovf, do_pop;
    logic                    stall, fire;
    tok_kind_t               kind;

    // Entry below the top is prefetched; the bottom entry is always zero
    assign ram_raddr = AW'(count_reg - CW'(2));

    idts_ram #(
        .WIDTH (COLUMN_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (fire && do_push),
        .waddr (count_reg[AW-1:0]),
        .wdata (q_col),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        has_entry  = (count_reg != '0);
        is_full    = (count_reg == CW'(STACK_DEPTH));
        two_left   = (count_reg == CW'(2));
        below_val  = two_left ? '0 : ram_rdata;

        try_indent = q_flags.line_end && q_flags.ok_indent && has_entry && (q_col > top_reg);
        do_push    = try_indent && !is_full;
        do_ovf     = try_indent && is_full;
        do_pop     = q_flags.line_end && !try_indent && q_flags.ok_dedent && has_entry
                   && (q_col < top_reg);

        priority if (do_push)
        begin
            kind = TOK_INDENT;
        end
        else if (do_ovf)
        begin
            kind = TOK_NONE;
        end
        else if (do_pop)
        begin
            kind = TOK_DEDENT;
        end
        else if (q_flags.line_end && q_flags.ok_newline && !q_flags.ok_indent)
        begin
            kind = TOK_NEWLINE;
        end
        else
        begin
            kind = TOK_NONE;
        end

        // Hold a pop until the prefetched entry matches the current depth
        stall = do_pop && !two_left && !below_ok_reg;
        fire  = q_valid && (!m_valid_reg || out_ready) && !stall;
        q_pop = fire;

        count_next    = count_reg;
        top_next      = top_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_kind_next   = m_kind_reg;
        m_ovf_next    = m_ovf_reg;
        below_ok_next = !(fire && (do_push || do_pop));

        if (fire)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = kind;
            m_ovf_next   = do_ovf;
            if (do_push)
            begin
                count_next = count_reg + CW'(1);
                top_next   = q_col;
            end
            else if (do_pop)
            begin
                count_next = count_reg - CW'(1);
                top_next   = below_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CW'(1);
            top_reg      <= '0;
            below_ok_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_kind_reg   <= TOK_NONE;
            m_ovf_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            top_reg      <= top_next;
            below_ok_reg <= below_ok_next;
            m_valid_reg  <= m_valid_next;
            m_kind_reg   <= m_kind_next;
            m_ovf_reg    <= m_ovf_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_ovf   = m_ovf_reg;

    `IDTS_ASSERT_IMP(a_count_range, 1'b1, (count_reg != '0) && (count_reg <= CW'(STACK_DEPTH)))
    `IDTS_ASSERT_NXT(a_pop_count, fire && do_pop, count_reg == $past(count_reg) - CW'(1))
    `IDTS_ASSERT_NXT(a_push_top, fire && do_push, top_reg == $past(q_col))
    `IDTS_ASSERT_IMP(a_ovf_no_token, m_valid_reg && m_ovf_reg, m_kind_reg == TOK_NONE)

endmodule
`default_nettype wire
